// ===== src/h264sps_pkg.sv =====
// shared types, constants and helper functions for the sps level / reference patcher
// depends on nothing; used by the parser, the bit packer and the top level
package h264sps_pkg;

   localparam int HOLD_BYTES_DEF = 48;
   localparam int MAX_RESULTS    = 52;
   localparam int RES_CNT_W      = 6;
   localparam int BIT_POS_W      = 10;
   localparam int CSR_ADDR_W     = 3;

   localparam logic [4:0] NAL_TYPE_SPS = 5'd7;
   localparam logic [7:0] LEVEL_RESET  = 8'd60;
   localparam logic [4:0] REFS_RESET   = 5'd16;

   // outcome codes, plus the undecided marker used inside the block
   typedef enum logic [2:0] {
      OUT_LEVEL_REFS, OUT_LEVEL_ONLY, OUT_NOT_SPS, OUT_SCALING,
      OUT_MALFORMED, OUT_CYCLES, OUT_OVERFLOW, OUT_UNDECIDED
   } outcome_type;

   typedef struct packed {
      logic                 done;
      outcome_type          code;
      logic [BIT_POS_W-1:0] refs_start;
      logic [BIT_POS_W-1:0] refs_end;
   } parse_result_type;

   typedef struct packed {
      logic       full;
      logic       has_residue;
      logic [7:0] word;
      logic [7:0] padded;
   } pack_status_type;

   // profiles that carry the chroma / bit depth / scaling fields
   function automatic logic high_profile(input logic [7:0] p);
      return p == 8'd100 || p == 8'd110 || p == 8'd122 || p == 8'd244 ||
             p == 8'd44  || p == 8'd83  || p == 8'd86  || p == 8'd118 ||
             p == 8'd128 || p == 8'd138 || p == 8'd139 || p == 8'd134 ||
             p == 8'd135;
   endfunction

   // leading zeros of an exp-golomb code word for a 6-bit code
   function automatic logic [2:0] ue_zeros(input logic [5:0] code);
      logic [2:0] nz;
      nz = 3'd0;
      for (int k = 1; k < 6; k++) begin
         if ((code >> k) != 6'd0) nz = 3'(k);
      end
      return nz;
   endfunction

endpackage

// ===== src/h264_sps_level_and_refs_patcher_unit.sv =====
// top level of the sps level / reference count patcher: stream ports, csr port, hold memory
// depends on h264sps_pkg, h264sps_parser and h264sps_packer
//
// Takes a NAL unit one word at a time, header first, and holds it while a bit-serial parser
// walks the raw bits (no emulation-prevention removal) through max_num_ref_frames. A unit that
// parses cleanly comes out with level_idc replaced by the level_override register and, when
// the coded reference count is below ref_frames_target, with that field re-coded as
// ue(ref_frames_target) and the tail shifted and zero padded; every other unit passes
// unchanged. The outcome code rides in rsp_tuser on the last word of each unit (zero on
// all others). A held word is taken in the accepting cycle, fed to the parser one bit per
// cycle and closed by the end and finish states. Once the decision is made the held words
// are replayed from the hold memory, each after a read wait state when passed unchanged, or
// re-packed bit by bit after a read wait and a load state, with the new reference code put
// in bit by bit. Words arriving after the decision go through the packer bit by bit
// (patched) or straight out (unchanged). Every output word may wait further on
// rsp_tready. A unit longer than HOLD_BYTES without a decision is passed unchanged with the
// overflow outcome. Registers at byte addresses 0 (level) and 4 (reference target) must
// be written over the csr port only while the block is idle; the block does not enforce it.
module h264_sps_level_and_refs_patcher_unit
   import h264sps_pkg::*;
#(
   parameter int HOLD_BYTES = HOLD_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // input stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] data_byte
   input  logic                  req_tlast,
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // [7:0] out_byte
   output logic                  rsp_tlast,
   output logic [2:0]            rsp_tuser,   // [2:0] outcome
   // csr port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam int ADDR_W = $clog2(HOLD_BYTES);
   localparam int CNT_W  = $clog2(HOLD_BYTES + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_FEED, S_STREAM, S_EMIT_IN, S_HELD_WAIT, S_HELD_EMIT, S_HDR_WAIT,
      S_HDR_EMIT, S_BYTE_WAIT, S_BYTE_LOAD, S_BIT, S_INSERT, S_END, S_FIN
   } state_type;

   state_type            state_ff, state_in;
   outcome_type          decision_ff, decision_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;
   logic [7:0]           in_byte_ff, in_byte_in;
   logic                 in_last_ff, in_last_in;
   logic [2:0]           bit_k_ff, bit_k_in;
   logic [7:0]           sr_ff, sr_in;
   logic [BIT_POS_W-1:0] pos_ff, pos_in;
   logic [3:0]           ins_k_ff, ins_k_in;
   logic                 inserted_ff, inserted_in;
   logic                 then_in_ff, then_in_in;
   logic [RES_CNT_W-1:0] res_cnt_ff, res_cnt_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [7:0]           pend_byte_ff, pend_byte_in;
   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   logic [7:0]           rsp_tdata_ff, rsp_tdata_in;
   logic                 rsp_tlast_ff, rsp_tlast_in;
   logic [2:0]           rsp_tuser_ff, rsp_tuser_in;
   logic [7:0]           level_ff, level_in;
   logic [4:0]           refs_target_ff, refs_target_in;

   // hold memory, one write and one registered read port
   logic [7:0]        hold_mem [HOLD_BYTES];
   logic [7:0]        rd_q_ff;
   logic              mem_we;

   logic              p_clear, p_start, p_bit_valid, p_bit;
   parse_result_type  p_res;
   logic              pk_clear, pk_push, pk_bit;
   pack_status_type   pk_st;

   logic              emit_fire;
   logic [7:0]        emit_byte;
   logic              emit_ok, out_free;
   logic [5:0]        code6;
   logic [2:0]        nz;
   logic [3:0]        ins_last, ins_sel;
   logic              ins_bit, cur_bit, in_refs, adv, patched;
   logic [CNT_W-1:0]  idx_next;

   h264sps_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .clear       (p_clear),
      .start       (p_start),
      .bit_valid   (p_bit_valid),
      .bit_in      (p_bit),
      .refs_target (refs_target_ff),
      .result      (p_res)
   );

   h264sps_packer u_packer (
      .clock  (clock),
      .reset  (reset),
      .clear  (pk_clear),
      .push   (pk_push),
      .bit_in (pk_bit),
      .status (pk_st)
   );

   always_ff @(posedge clock) begin
      if (mem_we) hold_mem[count_ff[ADDR_W-1:0]] <= req_tdata;
      rd_q_ff <= hold_mem[idx_ff[ADDR_W-1:0]];
   end

   always_comb begin
      // a word may be issued when the pending slot can move on into the output register
      out_free = !rsp_tvalid_ff || rsp_tready;
      emit_ok  = !pend_valid_ff || out_free;
      patched  = (decision_ff == OUT_LEVEL_REFS) || (decision_ff == OUT_LEVEL_ONLY);

      // new reference code ue(target): nz zeros then nz+1 bits of target+1
      code6    = {1'b0, refs_target_ff} + 6'd1;
      nz       = ue_zeros(code6);
      ins_last = {nz, 1'b0};
      ins_sel  = ins_last - ins_k_ff;
      ins_bit  = ({1'b0, ins_k_ff} < {2'b0, nz}) ? 1'b0 : code6[ins_sel[2:0]];

      // bits 16..23 after the header are level_idc
      cur_bit  = (pos_ff[BIT_POS_W-1:3] == (BIT_POS_W-3)'(2)) ? level_ff[3'd7 - pos_ff[2:0]]
                                                             : sr_ff[7];
      in_refs  = (decision_ff == OUT_LEVEL_REFS) && (pos_ff >= p_res.refs_start) &&
                 (pos_ff < p_res.refs_end);
      idx_next = idx_ff + CNT_W'(1);

      state_in       = state_ff;
      decision_in    = decision_ff;
      count_in       = count_ff;
      idx_in         = idx_ff;
      in_byte_in     = in_byte_ff;
      in_last_in     = in_last_ff;
      bit_k_in       = bit_k_ff;
      sr_in          = sr_ff;
      pos_in         = pos_ff;
      ins_k_in       = ins_k_ff;
      inserted_in    = inserted_ff;
      then_in_in     = then_in_ff;
      res_cnt_in     = res_cnt_ff;
      pend_valid_in  = pend_valid_ff;
      pend_byte_in   = pend_byte_ff;
      rsp_tvalid_in  = rsp_tvalid_ff;
      rsp_tdata_in   = rsp_tdata_ff;
      rsp_tlast_in   = rsp_tlast_ff;
      rsp_tuser_in   = rsp_tuser_ff;
      level_in       = level_ff;
      refs_target_in = refs_target_ff;

      emit_fire   = 1'b0;
      emit_byte   = '0;
      mem_we      = 1'b0;
      p_clear     = 1'b0;
      p_start     = 1'b0;
      p_bit_valid = 1'b0;
      p_bit       = 1'b0;
      pk_clear    = 1'b0;
      pk_push     = 1'b0;
      pk_bit      = 1'b0;
      adv         = 1'b0;

      if (rsp_tvalid_ff && rsp_tready) rsp_tvalid_in = 1'b0;

      // register writes
      if (csr_psel && csr_penable && csr_pwrite) begin
         if (csr_paddr[2]) refs_target_in = csr_pwdata[4:0];
         else              level_in       = csr_pwdata[7:0];
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               in_byte_in = req_tdata;
               in_last_in = req_tlast;
               res_cnt_in = '0;
               bit_k_in   = '0;
               if (patched) begin
                  state_in = S_STREAM;
               end else if (decision_ff != OUT_UNDECIDED) begin
                  state_in = S_EMIT_IN;
               end else if (count_ff == '0) begin
                  mem_we   = 1'b1;
                  count_in = CNT_W'(1);
                  if (req_tdata[4:0] != NAL_TYPE_SPS) begin
                     decision_in = OUT_NOT_SPS;
                     state_in    = S_EMIT_IN;
                  end else begin
                     p_start  = 1'b1;
                     state_in = S_END;
                  end
               end else if (count_ff >= CNT_W'(HOLD_BYTES)) begin
                  // hold overflow: replay what is held, then this word
                  decision_in = OUT_OVERFLOW;
                  idx_in      = '0;
                  then_in_in  = 1'b1;
                  state_in    = S_HELD_WAIT;
               end else begin
                  mem_we   = 1'b1;
                  count_in = count_ff + CNT_W'(1);
                  state_in = S_FEED;
               end
            end
         end
         S_FEED: begin
            p_bit_valid = 1'b1;
            p_bit       = in_byte_ff[3'd7 - bit_k_ff];
            bit_k_in    = bit_k_ff + 3'd1;
            if (p_res.done) begin
               decision_in = p_res.code;
               idx_in      = '0;
               then_in_in  = 1'b0;
               if (p_res.code == OUT_LEVEL_REFS || p_res.code == OUT_LEVEL_ONLY)
                  state_in = S_HDR_WAIT;
               else
                  state_in = S_HELD_WAIT;
            end else if (bit_k_ff == 3'd7) begin
               state_in = S_END;
            end
         end
         S_STREAM: begin
            if (emit_ok) begin
               pk_push  = 1'b1;
               pk_bit   = in_byte_ff[3'd7 - bit_k_ff];
               bit_k_in = bit_k_ff + 3'd1;
               if (pk_st.full) begin
                  emit_fire = 1'b1;
                  emit_byte = pk_st.word;
               end
               if (bit_k_ff == 3'd7) state_in = S_END;
            end
         end
         S_EMIT_IN: begin
            if (emit_ok) begin
               emit_fire = 1'b1;
               emit_byte = in_byte_ff;
               state_in  = S_END;
            end
         end
         S_HELD_WAIT: state_in = S_HELD_EMIT;
         S_HELD_EMIT: begin
            if (emit_ok) begin
               emit_fire = 1'b1;
               emit_byte = rd_q_ff;
               idx_in    = idx_next;
               if (idx_next == count_ff) state_in = then_in_ff ? S_EMIT_IN : S_END;
               else                      state_in = S_HELD_WAIT;
            end
         end
         S_HDR_WAIT: state_in = S_HDR_EMIT;
         S_HDR_EMIT: begin
            if (emit_ok) begin
               emit_fire   = 1'b1;
               emit_byte   = rd_q_ff;
               idx_in      = CNT_W'(1);
               pos_in      = '0;
               inserted_in = 1'b0;
               bit_k_in    = '0;
               state_in    = (count_ff == CNT_W'(1)) ? S_END : S_BYTE_WAIT;
            end
         end
         S_BYTE_WAIT: state_in = S_BYTE_LOAD;
         S_BYTE_LOAD: begin
            sr_in    = rd_q_ff;
            state_in = S_BIT;
         end
         S_BIT: begin
            if (decision_ff == OUT_LEVEL_REFS && !inserted_ff && pos_ff == p_res.refs_start) begin
               ins_k_in = '0;
               state_in = S_INSERT;
            end else begin
               if (in_refs) begin
                  // old reference field is dropped
                  adv = 1'b1;
               end else if (emit_ok) begin
                  pk_push = 1'b1;
                  pk_bit  = cur_bit;
                  adv     = 1'b1;
                  if (pk_st.full) begin
                     emit_fire = 1'b1;
                     emit_byte = pk_st.word;
                  end
               end
               if (adv) begin
                  sr_in    = {sr_ff[6:0], 1'b0};
                  pos_in   = pos_ff + BIT_POS_W'(1);
                  bit_k_in = bit_k_ff + 3'd1;
                  if (bit_k_ff == 3'd7) begin
                     idx_in   = idx_next;
                     state_in = (idx_next == count_ff) ? S_END : S_BYTE_WAIT;
                  end
               end
            end
         end
         S_INSERT: begin
            if (emit_ok) begin
               pk_push  = 1'b1;
               pk_bit   = ins_bit;
               ins_k_in = ins_k_ff + 4'd1;
               if (pk_st.full) begin
                  emit_fire = 1'b1;
                  emit_byte = pk_st.word;
               end
               if (ins_k_ff == ins_last) begin
                  inserted_in = 1'b1;
                  state_in    = S_BIT;
               end
            end
         end
         S_END: begin
            if (in_last_ff && decision_ff == OUT_UNDECIDED) begin
               // unit ended before a decision: short or truncated
               decision_in = (count_ff < CNT_W'(4)) ? OUT_NOT_SPS : OUT_MALFORMED;
               idx_in      = '0;
               then_in_in  = 1'b0;
               state_in    = S_HELD_WAIT;
            end else if (in_last_ff && patched && pk_st.has_residue) begin
               if (emit_ok) begin
                  emit_fire = 1'b1;
                  emit_byte = pk_st.padded;
                  pk_clear  = 1'b1;
                  state_in  = S_FIN;
               end
            end else begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  rsp_tvalid_in = 1'b1;
                  rsp_tdata_in  = pend_byte_ff;
                  rsp_tlast_in  = in_last_ff;
                  rsp_tuser_in  = in_last_ff ? decision_ff : OUT_LEVEL_REFS;
                  pend_valid_in = 1'b0;
               end
               if (in_last_ff) begin
                  count_in    = '0;
                  decision_in = OUT_UNDECIDED;
                  p_clear     = 1'b1;
                  pk_clear    = 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // words of a step beyond the cap are dropped; the pending slot keeps the last kept one
      if (emit_fire && res_cnt_ff < RES_CNT_W'(MAX_RESULTS)) begin
         res_cnt_in    = res_cnt_ff + RES_CNT_W'(1);
         pend_byte_in  = emit_byte;
         pend_valid_in = 1'b1;
         if (pend_valid_ff) begin
            rsp_tvalid_in = 1'b1;
            rsp_tdata_in  = pend_byte_ff;
            rsp_tlast_in  = 1'b0;
            rsp_tuser_in  = OUT_LEVEL_REFS;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         decision_ff    <= OUT_UNDECIDED;
         count_ff       <= '0;
         idx_ff         <= '0;
         bit_k_ff       <= '0;
         pos_ff         <= '0;
         ins_k_ff       <= '0;
         inserted_ff    <= 1'b0;
         then_in_ff     <= 1'b0;
         res_cnt_ff     <= '0;
         pend_valid_ff  <= 1'b0;
         rsp_tvalid_ff  <= 1'b0;
         in_last_ff     <= 1'b0;
         level_ff       <= LEVEL_RESET;
         refs_target_ff <= REFS_RESET;
      end else begin
         state_ff       <= state_in;
         decision_ff    <= decision_in;
         count_ff       <= count_in;
         idx_ff         <= idx_in;
         bit_k_ff       <= bit_k_in;
         pos_ff         <= pos_in;
         ins_k_ff       <= ins_k_in;
         inserted_ff    <= inserted_in;
         then_in_ff     <= then_in_in;
         res_cnt_ff     <= res_cnt_in;
         pend_valid_ff  <= pend_valid_in;
         rsp_tvalid_ff  <= rsp_tvalid_in;
         in_last_ff     <= in_last_in;
         level_ff       <= level_in;
         refs_target_ff <= refs_target_in;
      end
      in_byte_ff   <= in_byte_in;
      sr_ff        <= sr_in;
      pend_byte_ff <= pend_byte_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tlast_ff <= rsp_tlast_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[2] ? {27'd0, refs_target_ff} : {24'd0, level_ff};

   // an outcome only travels on the closing word of a unit
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tuser == 3'd0)
      else $error("outcome on a word that does not close the unit");

   // no new word is taken while a pending word is still held back
   assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !pend_valid_ff)
      else $error("input accepted with a pending word");

   // a patch decision needs at least the profile, constraint and level words
   assert property (@(posedge clock) disable iff (reset)
      (decision_ff == OUT_LEVEL_REFS || decision_ff == OUT_LEVEL_ONLY) |->
      count_ff >= CNT_W'(4))
      else $error("patch decision on a short unit");

   // words per input step never exceed the cap
   assert property (@(posedge clock) disable iff (reset)
      res_cnt_ff <= RES_CNT_W'(MAX_RESULTS))
      else $error("result count beyond the cap");

endmodule

// ===== src/h264sps_parser.sv =====
// bit-serial sps field parser: profile, level and exp-golomb fields up to max_num_ref_frames
// depends on h264sps_pkg
module h264sps_parser
   import h264sps_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             clear,
   input  logic             start,
   input  logic             bit_valid,
   input  logic             bit_in,
   input  logic [4:0]       refs_target,
   output parse_result_type result
);

   typedef enum logic [4:0] {
      PH_HEADER, PH_PROFILE, PH_CONSTR, PH_LEVEL, PH_SPSID, PH_CFI, PH_SEPCOL,
      PH_BDL, PH_BDC, PH_BYPASS, PH_SCALING, PH_MAXFN, PH_POCTYPE, PH_MAXPOC,
      PH_DZERO, PH_OFFNR, PH_OFFTB, PH_NCYCLE, PH_CYCLE, PH_REFS, PH_DONE
   } phase_type;

   phase_type            phase_ff, phase_in;
   logic [3:0]           fixed_left_ff, fixed_left_in;
   logic [5:0]           zero_cnt_ff, zero_cnt_in;
   logic                 in_suffix_ff, in_suffix_in;
   logic [5:0]           suffix_left_ff, suffix_left_in;
   logic [31:0]          acc_ff, acc_in;
   logic [7:0]           profile_ff, profile_in;
   logic [7:0]           cycle_ff, cycle_in;
   logic [BIT_POS_W-1:0] bit_pos_ff, bit_pos_in;
   logic [BIT_POS_W-1:0] refs_start_ff, refs_start_in;
   logic [BIT_POS_W-1:0] refs_end_ff, refs_end_in;

   logic        done_c;
   outcome_type code_c;
   logic        fdone;
   logic [31:0] value;
   logic [31:0] acc_sh;
   logic [31:0] mask;
   logic [7:0]  cyc_dec;
   logic        do_enter;
   phase_type   enter_ph;

   always_comb begin
      phase_in       = phase_ff;
      fixed_left_in  = fixed_left_ff;
      zero_cnt_in    = zero_cnt_ff;
      in_suffix_in   = in_suffix_ff;
      suffix_left_in = suffix_left_ff;
      acc_in         = acc_ff;
      profile_in     = profile_ff;
      cycle_in       = cycle_ff;
      bit_pos_in     = bit_pos_ff;
      refs_start_in  = refs_start_ff;
      refs_end_in    = refs_end_ff;
      done_c         = 1'b0;
      code_c         = OUT_MALFORMED;
      fdone          = 1'b0;
      value          = '0;
      do_enter       = 1'b0;
      enter_ph       = phase_ff;
      acc_sh         = {acc_ff[30:0], bit_in};
      mask           = ~(32'hFFFF_FFFF << zero_cnt_ff[4:0]);
      cyc_dec        = cycle_ff - 8'd1;

      if (start) begin
         do_enter = 1'b1;
         enter_ph = PH_PROFILE;
      end else if (bit_valid) begin
         bit_pos_in = bit_pos_ff + BIT_POS_W'(1);
         if (fixed_left_ff != 4'd0) begin
            acc_in        = acc_sh;
            fixed_left_in = fixed_left_ff - 4'd1;
            if (fixed_left_ff == 4'd1) begin
               fdone = 1'b1;
               value = acc_sh;
            end
         end else if (!in_suffix_ff) begin
            if (!bit_in) begin
               zero_cnt_in = zero_cnt_ff + 6'd1;
               // prefix longer than 31 zeros
               if (zero_cnt_ff == 6'd31) begin
                  done_c   = 1'b1;
                  code_c   = OUT_MALFORMED;
                  phase_in = PH_DONE;
               end
            end else if (zero_cnt_ff == 6'd0) begin
               fdone = 1'b1;
            end else begin
               in_suffix_in   = 1'b1;
               suffix_left_in = zero_cnt_ff;
               acc_in         = '0;
            end
         end else begin
            acc_in         = acc_sh;
            suffix_left_in = suffix_left_ff - 6'd1;
            if (suffix_left_ff == 6'd1) begin
               fdone = 1'b1;
               value = mask + acc_sh;
            end
         end

         if (fdone) begin
            do_enter = 1'b1;
            case (phase_ff)
               PH_PROFILE: begin
                  profile_in = value[7:0];
                  enter_ph   = PH_CONSTR;
               end
               PH_CONSTR:  enter_ph = PH_LEVEL;
               PH_LEVEL:   enter_ph = PH_SPSID;
               PH_SPSID:   enter_ph = high_profile(profile_ff) ? PH_CFI : PH_MAXFN;
               PH_CFI:     enter_ph = (value == 32'd3) ? PH_SEPCOL : PH_BDL;
               PH_SEPCOL:  enter_ph = PH_BDL;
               PH_BDL:     enter_ph = PH_BDC;
               PH_BDC:     enter_ph = PH_BYPASS;
               PH_BYPASS:  enter_ph = PH_SCALING;
               PH_SCALING: begin
                  if (value != 32'd0) begin
                     do_enter = 1'b0;
                     done_c   = 1'b1;
                     code_c   = OUT_SCALING;
                     phase_in = PH_DONE;
                  end else begin
                     enter_ph = PH_MAXFN;
                  end
               end
               PH_MAXFN:   enter_ph = PH_POCTYPE;
               PH_POCTYPE: begin
                  if (value == 32'd0)      enter_ph = PH_MAXPOC;
                  else if (value == 32'd1) enter_ph = PH_DZERO;
                  else                     enter_ph = PH_REFS;
               end
               PH_MAXPOC:  enter_ph = PH_REFS;
               PH_DZERO:   enter_ph = PH_OFFNR;
               PH_OFFNR:   enter_ph = PH_OFFTB;
               PH_OFFTB:   enter_ph = PH_NCYCLE;
               PH_NCYCLE: begin
                  if (value[31:8] != 24'd0) begin
                     do_enter = 1'b0;
                     done_c   = 1'b1;
                     code_c   = OUT_CYCLES;
                     phase_in = PH_DONE;
                  end else begin
                     cycle_in = value[7:0];
                     enter_ph = (value == 32'd0) ? PH_REFS : PH_CYCLE;
                  end
               end
               PH_CYCLE: begin
                  cycle_in = cyc_dec;
                  enter_ph = (cyc_dec == 8'd0) ? PH_REFS : PH_CYCLE;
               end
               PH_REFS: begin
                  do_enter    = 1'b0;
                  refs_end_in = bit_pos_in;
                  done_c      = 1'b1;
                  code_c      = (value < {27'd0, refs_target}) ? OUT_LEVEL_REFS
                                                               : OUT_LEVEL_ONLY;
                  phase_in    = PH_DONE;
               end
               default: begin
                  do_enter = 1'b0;
                  done_c   = 1'b1;
                  code_c   = OUT_MALFORMED;
                  phase_in = PH_DONE;
               end
            endcase
         end
      end

      if (do_enter) begin
         phase_in       = enter_ph;
         acc_in         = '0;
         zero_cnt_in    = '0;
         in_suffix_in   = 1'b0;
         suffix_left_in = '0;
         case (enter_ph)
            PH_PROFILE, PH_CONSTR, PH_LEVEL:              fixed_left_in = 4'd8;
            PH_SEPCOL, PH_BYPASS, PH_SCALING, PH_DZERO:   fixed_left_in = 4'd1;
            default:                                      fixed_left_in = 4'd0;
         endcase
         if (enter_ph == PH_REFS) refs_start_in = bit_pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         phase_ff       <= PH_HEADER;
         fixed_left_ff  <= '0;
         zero_cnt_ff    <= '0;
         in_suffix_ff   <= 1'b0;
         suffix_left_ff <= '0;
         acc_ff         <= '0;
         profile_ff     <= '0;
         cycle_ff       <= '0;
         bit_pos_ff     <= '0;
         refs_start_ff  <= '0;
         refs_end_ff    <= '0;
      end else begin
         phase_ff       <= phase_in;
         fixed_left_ff  <= fixed_left_in;
         zero_cnt_ff    <= zero_cnt_in;
         in_suffix_ff   <= in_suffix_in;
         suffix_left_ff <= suffix_left_in;
         acc_ff         <= acc_in;
         profile_ff     <= profile_in;
         cycle_ff       <= cycle_in;
         bit_pos_ff     <= bit_pos_in;
         refs_start_ff  <= refs_start_in;
         refs_end_ff    <= refs_end_in;
      end
   end

   assign result.done       = done_c;
   assign result.code       = code_c;
   assign result.refs_start = refs_start_ff;
   assign result.refs_end   = refs_end_ff;

endmodule

// ===== src/h264sps_packer.sv =====
// bit packer: collects output bits msb first into words, pads the residue at unit end
// depends on h264sps_pkg
module h264sps_packer
   import h264sps_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            clear,
   input  logic            push,
   input  logic            bit_in,
   output pack_status_type status
);

   logic [6:0]  acc_ff, acc_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [15:0] wide;

   always_comb begin
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      if (push) begin
         if (cnt_ff == 3'd7) begin
            acc_in = '0;
            cnt_in = '0;
         end else begin
            acc_in = {acc_ff[5:0], bit_in};
            cnt_in = cnt_ff + 3'd1;
         end
      end
      wide = {9'd0, acc_ff} << (4'd8 - {1'b0, cnt_ff});
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         acc_ff <= '0;
         cnt_ff <= '0;
      end else begin
         acc_ff <= acc_in;
         cnt_ff <= cnt_in;
      end
   end

   assign status.full        = (cnt_ff == 3'd7);
   assign status.has_residue = (cnt_ff != 3'd0);
   assign status.word        = {acc_ff, bit_in};
   assign status.padded      = wide[7:0];

endmodule

// ===== test/tb_top.sv =====
// testbench for the sps level / reference count patcher: scoreboard class plus stream and csr drivers
// depends on h264sps_pkg and h264_sps_level_and_refs_patcher_unit
`timescale 1ns / 100ps

module tb_top
   import h264sps_pkg::*;
();

   // parse steps of the bit-serial predictor
   typedef enum int {
      PS_HEADER, PS_PROFILE, PS_CONSTR, PS_LEVEL, PS_SPSID, PS_CFI, PS_SEPCOL,
      PS_BDL, PS_BDC, PS_BYPASS, PS_SCALING, PS_MAXFN, PS_POCTYPE, PS_MAXPOC,
      PS_DZERO, PS_OFFNR, PS_OFFTB, PS_NCYCLE, PS_CYCLE, PS_REFS, PS_DONE
   } parse_step_type;

   // csr byte addresses
   localparam logic [CSR_ADDR_W-1:0] ADDR_LEVEL = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] ADDR_REFS  = 3'd4;

   localparam int IDLE_LIMIT = 30000;

   typedef struct {
      logic [7:0]  word;
      logic        last;
      outcome_type code;
   } sps_word_type;

   // predicts the rewritten unit word by word and checks the block's output against it
   class sps_patch_scoreboard;
      logic [7:0]     level_reg;
      logic [4:0]     refs_reg;
      logic [7:0]     held [HOLD_BYTES_DEF];
      int unsigned    held_cnt;
      parse_step_type step;
      int unsigned    zero_cnt, suf_left, fix_left, bit_pos;
      bit             in_suf;
      logic [31:0]    acc;
      logic [7:0]     profile;
      logic [7:0]     cyc_left;
      int unsigned    refs_start, refs_end;
      outcome_type    verdict;
      logic [15:0]    residue;
      int unsigned    residue_cnt;
      sps_word_type   expected_words [$];
      sps_word_type   step_words [$];
      int             errors;

      function new();
         level_reg = LEVEL_RESET;
         refs_reg  = REFS_RESET;
         errors    = 0;
         unit_clear();
      endfunction

      function void unit_clear();
         held_cnt = 0; step = PS_HEADER; zero_cnt = 0; acc = 0; profile = 0;
         cyc_left = 0; refs_start = 0; refs_end = 0; verdict = OUT_UNDECIDED;
         residue = 0; residue_cnt = 0; fix_left = 0; suf_left = 0; in_suf = 0;
         bit_pos = 0;
      endfunction

      function void put_word(logic [7:0] w);
         sps_word_type e;
         if (step_words.size() >= MAX_RESULTS) return;
         e.word = w; e.last = 0; e.code = OUT_LEVEL_REFS;
         step_words.insert(step_words.size(), e);
      endfunction

      function void put_bit(logic b);
         residue = {residue[14:0], b};
         residue_cnt++;
         if (residue_cnt == 8) begin
            put_word(residue[7:0]);
            residue = 0; residue_cnt = 0;
         end
      endfunction

      function bit is_high(logic [7:0] p);
         return p inside {8'd100, 8'd110, 8'd122, 8'd244, 8'd44, 8'd83, 8'd86,
                          8'd118, 8'd128, 8'd138, 8'd139, 8'd134, 8'd135};
      endfunction

      function void enter_step(parse_step_type s);
         step = s; acc = 0; zero_cnt = 0; in_suf = 0; suf_left = 0; fix_left = 0;
         if (s inside {PS_PROFILE, PS_CONSTR, PS_LEVEL}) fix_left = 8;
         if (s inside {PS_SEPCOL, PS_BYPASS, PS_SCALING, PS_DZERO}) fix_left = 1;
         if (s == PS_REFS) refs_start = bit_pos & 32'h3ff;
      endfunction

      function void field_end(logic [31:0] v);
         case (step)
            PS_PROFILE: begin profile = v[7:0]; enter_step(PS_CONSTR); end
            PS_CONSTR:  enter_step(PS_LEVEL);
            PS_LEVEL:   enter_step(PS_SPSID);
            PS_SPSID:   enter_step(is_high(profile) ? PS_CFI : PS_MAXFN);
            PS_CFI:     enter_step(v == 3 ? PS_SEPCOL : PS_BDL);
            PS_SEPCOL:  enter_step(PS_BDL);
            PS_BDL:     enter_step(PS_BDC);
            PS_BDC:     enter_step(PS_BYPASS);
            PS_BYPASS:  enter_step(PS_SCALING);
            PS_SCALING: begin
               if (v != 0) begin verdict = OUT_SCALING; step = PS_DONE; end
               else enter_step(PS_MAXFN);
            end
            PS_MAXFN:   enter_step(PS_POCTYPE);
            PS_POCTYPE: enter_step(v == 0 ? PS_MAXPOC : (v == 1 ? PS_DZERO : PS_REFS));
            PS_MAXPOC:  enter_step(PS_REFS);
            PS_DZERO:   enter_step(PS_OFFNR);
            PS_OFFNR:   enter_step(PS_OFFTB);
            PS_OFFTB:   enter_step(PS_NCYCLE);
            PS_NCYCLE: begin
               if (v > 255) begin verdict = OUT_CYCLES; step = PS_DONE; end
               else begin
                  cyc_left = v[7:0];
                  enter_step(v == 0 ? PS_REFS : PS_CYCLE);
               end
            end
            PS_CYCLE: begin
               cyc_left = cyc_left - 8'd1;
               enter_step(cyc_left == 0 ? PS_REFS : PS_CYCLE);
            end
            PS_REFS: begin
               refs_end = bit_pos & 32'h3ff;
               verdict = (v < refs_reg) ? OUT_LEVEL_REFS : OUT_LEVEL_ONLY;
               step = PS_DONE;
            end
            default: begin step = PS_DONE; verdict = OUT_MALFORMED; end
         endcase
      endfunction

      function void parse_bit(logic b);
         logic [31:0] one;
         one = 32'd1;
         bit_pos++;
         if (fix_left > 0) begin
            acc = {acc[30:0], b};
            fix_left--;
            if (fix_left == 0) field_end(acc);
            return;
         end
         if (!in_suf) begin
            if (!b) begin
               zero_cnt++;
               if (zero_cnt > 31) begin verdict = OUT_MALFORMED; step = PS_DONE; end
               return;
            end
            if (zero_cnt == 0) begin field_end(32'd0); return; end
            in_suf = 1; suf_left = zero_cnt; acc = 0;
            return;
         end
         acc = {acc[30:0], b};
         suf_left--;
         if (suf_left == 0) field_end(((one << zero_cnt) - one) + acc);
      endfunction

      function void replay_held();
         for (int i = 0; i < held_cnt && i < HOLD_BYTES_DEF; i++) put_word(held[i]);
      endfunction

      // rebuilds the unit from the held words with the new level and, if due, the new refs code
      function void replay_patched();
         int unsigned total, code, nz, idx;
         logic b;
         total = (held_cnt - 1) * 8;
         put_word(held[0]);
         for (int unsigned i = 0; i < total; i++) begin
            if (verdict == OUT_LEVEL_REFS && i == refs_start) begin
               code = refs_reg + 1;
               nz = 0;
               while ((code >> (nz + 1)) != 0) nz++;
               for (int j = 0; j < nz; j++) put_bit(1'b0);
               for (int j = nz; j >= 0; j--) put_bit(code[j]);
            end
            if (verdict == OUT_LEVEL_REFS && i >= refs_start && i < refs_end) continue;
            if (i >= 16 && i < 24) b = level_reg[23 - i];
            else begin
               idx = 1 + (i >> 3);
               b = (idx < HOLD_BYTES_DEF) ? held[idx][7 - (i & 7)] : 1'b0;
            end
            put_bit(b);
         end
      endfunction

      // accepted input word: work out every output word it releases
      function void note_input(logic [7:0] w, logic l);
         step_words.delete();
         if (verdict inside {OUT_LEVEL_REFS, OUT_LEVEL_ONLY}) begin
            for (int k = 7; k >= 0; k--) put_bit(w[k]);
         end else if (verdict != OUT_UNDECIDED) begin
            put_word(w);
         end else if (held_cnt == 0) begin
            held[0] = w; held_cnt = 1;
            if (w[4:0] != NAL_TYPE_SPS) begin verdict = OUT_NOT_SPS; put_word(w); end
            else enter_step(PS_PROFILE);
         end else if (held_cnt >= HOLD_BYTES_DEF) begin
            verdict = OUT_OVERFLOW;
            replay_held();
            put_word(w);
         end else begin
            held[held_cnt] = w; held_cnt++;
            for (int k = 7; k >= 0 && verdict == OUT_UNDECIDED; k--) parse_bit(w[k]);
            if (verdict inside {OUT_LEVEL_REFS, OUT_LEVEL_ONLY}) replay_patched();
            else if (verdict != OUT_UNDECIDED) replay_held();
         end
         if (verdict == OUT_UNDECIDED && l) begin
            verdict = (held_cnt < 4) ? OUT_NOT_SPS : OUT_MALFORMED;
            replay_held();
         end
         if (l) begin
            if (verdict inside {OUT_LEVEL_REFS, OUT_LEVEL_ONLY} && residue_cnt > 0)
               put_word(8'(residue << (8 - residue_cnt)));
            if (step_words.size() > 0) begin
               step_words[$].last = 1;
               step_words[$].code = verdict;
            end
            unit_clear();
         end
         foreach (step_words[i]) expected_words.insert(expected_words.size(), step_words[i]);
      endfunction

      task report(string what, logic [7:0] got, logic [7:0] want);
         errors++;
         $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      endtask

      task check_word(logic [7:0] w, logic l, logic [2:0] c);
         sps_word_type e;
         if (expected_words.size() == 0) begin
            report("unexpected output word", w, 8'h0);
            return;
         end
         e = expected_words.pop_front();
         if (w !== e.word) report("out_byte", w, e.word);
         if (l !== e.last) report("out_last", 8'(l), 8'(e.last));
         if (c !== e.code) report("outcome", 8'(c), 8'(e.code));
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid, req_tready, req_tlast;
   logic [7:0]            req_tdata;
   logic                  rsp_tvalid, rsp_tready, rsp_tlast;
   logic [7:0]            rsp_tdata;
   logic [2:0]            rsp_tuser;
   logic                  csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata, csr_prdata;

   sps_patch_scoreboard sb;
   int   idle_cycles;
   bit   moved;
   int   burst_left;
   int   words_sent;
   bit   stall_on;
   logic [15:0] stall_mask;
   int   stall_idx;
   bit   unit_bits [$];
   logic [7:0] unit_words [$];

   h264_sps_level_and_refs_patcher_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // receiver: stalls follow a random 16-bit mask that is redrawn now and then,
   // with spells of no stalling at all
   always @(posedge clock) begin
      if (stall_idx == 15) begin
         stall_mask <= 16'($urandom);
         stall_on   <= ($urandom_range(0, 3) != 0);
      end
      stall_idx  <= (stall_idx + 1) % 16;
      rsp_tready <= stall_on ? stall_mask[stall_idx] : 1'b1;
   end

   // outputs only move at the rising edge, so the handshake is sampled mid-cycle
   always @(negedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_word(rsp_tdata, rsp_tlast, rsp_tuser);
         moved = 1;
      end
   end

   // watchdog on cycles with no traffic at all
   always @(posedge clock) begin
      if (moved) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      moved = 0;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL h264_sps_level_and_refs_patcher_unit");
         $finish;
      end
   end

   // one input word; entered and left at a rising edge
   task automatic send_word(input logic [7:0] w, input logic l);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         burst_left = $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1;
      req_tdata  <= w;
      req_tlast  <= l;
      forever begin
         @(negedge clock);
         if (req_tready) break;
      end
      sb.note_input(w, l);
      moved = 1;
      words_sent++;
      @(posedge clock);
   endtask

   task automatic send_unit();
      foreach (unit_words[i]) send_word(unit_words[i], i == unit_words.size() - 1);
   endtask

   // waits for the block to drain, then lets its internal replay settle
   task automatic wait_drained();
      req_tvalid <= 0;
      while (sb.expected_words.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] a, input logic [31:0] d);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1; csr_paddr <= a; csr_pwdata <= d;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      // register takes the value at this edge
      if (a == ADDR_LEVEL) sb.level_reg = d[7:0];
      else sb.refs_reg = d[4:0];
      moved = 1;
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
   endtask

   task automatic set_regs(input logic [7:0] lvl, input logic [4:0] refs);
      wait_drained();
      csr_write(ADDR_LEVEL, {24'h0, lvl});
      csr_write(ADDR_REFS, {27'h0, refs});
      @(posedge clock);
   endtask

   // bit builders for the sps payload
   function automatic void put_bits(input longint unsigned v, input int n);
      for (int i = n - 1; i >= 0; i--) unit_bits.insert(unit_bits.size(), v[i]);
   endfunction

   function automatic void put_ue(input longint unsigned v);
      longint unsigned code;
      int nz;
      code = v + 1;
      nz = 0;
      while ((code >> (nz + 1)) != 0) nz++;
      put_bits(0, nz);
      put_bits(code, nz + 1);
   endfunction

   // header plus packed bits; the stop bit closes the unit, then zero fill
   function automatic void close_unit(input int cut);
      logic [7:0] w;
      unit_bits.insert(unit_bits.size(), 1'b1);
      while (unit_bits.size() % 8 != 0) unit_bits.insert(unit_bits.size(), 1'b0);
      unit_words.delete();
      unit_words.insert(unit_words.size(), {1'($urandom), 2'($urandom), NAL_TYPE_SPS});
      for (int i = 0; i < unit_bits.size(); i += 8) begin
         for (int k = 0; k < 8; k++) w[7 - k] = unit_bits[i + k];
         unit_words.insert(unit_words.size(), w);
      end
      if (cut > 0) while (unit_words.size() > cut) void'(unit_words.pop_back());
      unit_bits.delete();
   endfunction

   // sps through max_num_ref_frames with random filler after it
   function automatic void build_sps(input int prof, input int cfi, input bit scal,
                                     input int poc, input int ncyc, input int refs,
                                     input int tail, input int cut);
      put_bits(prof, 8);
      put_bits($urandom, 8);
      put_bits($urandom, 8);
      put_ue($urandom_range(0, 31));
      if (prof inside {100, 110, 122, 244, 44, 83, 86, 118, 128, 138, 139, 134, 135}) begin
         put_ue(cfi);
         if (cfi == 3) put_bits($urandom, 1);
         put_ue($urandom_range(0, 6));
         put_ue($urandom_range(0, 6));
         put_bits($urandom, 1);
         put_bits(scal, 1);
      end
      put_ue($urandom_range(0, 12));
      put_ue(poc);
      if (poc == 0) put_ue($urandom_range(0, 12));
      else if (poc == 1) begin
         put_bits($urandom, 1);
         put_ue($urandom_range(0, 300));
         put_ue($urandom_range(0, 300));
         put_ue(ncyc);
         if (ncyc <= 255)
            for (int i = 0; i < ncyc; i++) put_ue($urandom_range(0, 20));
      end
      put_ue(refs);
      for (int i = 0; i < tail * 8; i++) unit_bits.insert(unit_bits.size(), 1'($urandom));
      close_unit(cut);
   endfunction

   function automatic int pick_profile();
      int list [16] = '{66, 77, 88, 100, 110, 122, 244, 44, 83, 86, 118, 128, 138,
                        139, 134, 135};
      return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : list[$urandom_range(0, 15)];
   endfunction

   // sps whose parse never decides inside the hold memory
   function automatic void build_overflow();
      put_bits(66, 8); put_bits(0, 16); put_ue(0); put_ue(4); put_ue(1);
      put_bits(0, 1); put_ue(5); put_ue(5); put_ue(24);
      for (int i = 0; i < 24; i++) put_ue($urandom_range(500, 4000));
      put_ue(3);
      close_unit(0);
   endfunction

   // 40 zero prefix straight after the seq_parameter_set_id
   function automatic void build_long_prefix();
      put_bits(77, 8); put_bits($urandom, 16); put_ue(0);
      put_bits(0, 40);
      for (int i = 0; i < 8; i++) unit_bits.insert(unit_bits.size(), 1'($urandom));
      close_unit(0);
   endfunction

   function automatic void build_noise(input int len, input bit sps_header);
      logic [7:0] h;
      unit_words.delete();
      h = 8'($urandom);
      if (sps_header) h[4:0] = NAL_TYPE_SPS;
      else if (h[4:0] == NAL_TYPE_SPS) h[0] = 1'b0;
      unit_words.insert(unit_words.size(), h);
      for (int i = 1; i < len; i++) unit_words.insert(unit_words.size(), 8'($urandom));
   endfunction

   task automatic random_unit();
      int r;
      r = $urandom_range(0, 99);
      if (r < 68)
         build_sps(pick_profile(), $urandom_range(0, 3), 0, $urandom_range(0, 3),
                   $urandom_range(0, 4), $urandom_range(0, 34), $urandom_range(0, 8), 0);
      else if (r < 76)
         build_sps(pick_profile(), $urandom_range(0, 3), 0, $urandom_range(0, 2),
                   $urandom_range(0, 4), $urandom_range(0, 31), 4, $urandom_range(1, 10));
      else if (r < 83) build_noise($urandom_range(1, 10), 0);
      else if (r < 87) build_noise($urandom_range(1, 12), 1);
      else if (r < 91)
         build_sps(100, $urandom_range(0, 3), 1, 0, 0, 3, $urandom_range(0, 3), 0);
      else if (r < 94) build_long_prefix();
      else if (r < 97) build_sps(66, 0, 0, 1, $urandom_range(256, 400), 2, 2, 0);
      else build_overflow();
      send_unit();
   endtask

   initial begin
      sb = new();
      reset = 1;
      req_tvalid = 0; req_tdata = 0; req_tlast = 0;
      rsp_tready = 0;
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0; csr_paddr = 0; csr_pwdata = 0;
      stall_mask = 16'hffff; stall_idx = 0; stall_on = 0;
      idle_cycles = 0; moved = 0; burst_left = 0; words_sent = 0;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: reset register values first
      build_noise(1, 0); send_unit();                     // not an sps, single word
      build_noise(1, 1); send_unit();                     // lone sps header
      build_noise(3, 1); send_unit();                     // short unit
      build_sps(66, 0, 0, 2, 0, 0, 1, 0); send_unit();    // refs below target
      build_sps(100, 3, 0, 0, 0, 31, 0, 0); send_unit();  // high profile, level only
      build_sps(100, 1, 1, 0, 0, 1, 0, 0); send_unit();   // scaling matrix present
      build_sps(77, 0, 0, 1, 3, 1, 0, 0); send_unit();    // cycle offsets
      build_sps(77, 0, 0, 1, 256, 1, 0, 0); send_unit();  // too many cycle offsets
      build_long_prefix(); send_unit();
      build_sps(66, 0, 0, 1, 2, 1, 2, 5); send_unit();    // truncated
      build_overflow(); send_unit();

      set_regs(8'd255, 5'd31);
      build_sps(66, 0, 0, 2, 0, 30, 2, 0); send_unit();
      set_regs(8'd0, 5'd0);
      build_sps(88, 0, 0, 0, 0, 0, 1, 0); send_unit();

      // random part, with a register change roughly every hundred words
      while (words_sent < 410) begin
         if (words_sent % 100 < 12 && $urandom_range(0, 2) == 0)
            set_regs(8'($urandom), 5'($urandom));
         random_unit();
      end

      wait_drained();
      repeat (60) @(posedge clock);
      if (sb.errors == 0 && sb.expected_words.size() == 0)
         $display("PASS h264_sps_level_and_refs_patcher_unit");
      else
         $display("FAIL h264_sps_level_and_refs_patcher_unit");
      $finish;
   end

endmodule
